@@ hdl/cfsf_pkg.sv @@
// Shared types and constants for the condition filter and segment finder.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package cfsf_pkg;

    // Sizes.
    localparam int NUM_CONDITIONS = 2;
    localparam int INDEX_WIDTH    = 40;
    localparam int VALUE_WIDTH    = 64;
    localparam int MODE_WIDTH     = 4;
    localparam int COUNT_WIDTH    = 2;
    localparam int CFG_IDX_WIDTH  = 4;
    localparam int IN_DATA_WIDTH  = 3 * VALUE_WIDTH;
    localparam int OUT_DATA_WIDTH = 2 * VALUE_WIDTH + 2 * INDEX_WIDTH;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_COUNT      = 4'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_A_MODE     = 4'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_A_LOW      = 4'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_A_HIGH     = 4'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_B_MODE     = 4'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_B_LOW      = 4'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_B_HIGH     = 4'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST_ROW_INDEX = 4'd7;

    // Mode bit that selects OR combining for the second condition.
    localparam int MODE_OR_BIT = 3;

    // Condition types held in mode bits 2:0.
    typedef enum logic [2:0] {
        COND_RANGE     = 3'd0,
        COND_GREATER   = 3'd1,
        COND_LESS      = 3'd2,
        COND_EQUAL     = 3'd3,
        COND_NOT_EQUAL = 3'd4
    } cond_type_t;

    // One condition's settings.
    typedef struct packed {
        logic [MODE_WIDTH-1:0]         mode;
        logic signed [VALUE_WIDTH-1:0] low;
        logic signed [VALUE_WIDTH-1:0] high;
    } cond_cfg_t;

    // Whole configuration.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cond_count;
        cond_cfg_t              cond_a;
        cond_cfg_t              cond_b;
        logic [INDEX_WIDTH-1:0] first_row_index;
    } cfsf_cfg_t;

    // One registered input row.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] time_stamp;
        logic signed [VALUE_WIDTH-1:0] value_a;
        logic signed [VALUE_WIDTH-1:0] value_b;
        logic                          value_a_nan;
        logic                          value_b_nan;
        logic                          last_row;
    } row_t;

    // One segment result.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] seg_start_time;
        logic signed [VALUE_WIDTH-1:0] seg_end_time;
        logic [INDEX_WIDTH-1:0]        seg_start_index;
        logic [INDEX_WIDTH-1:0]        seg_end_index;
    } segment_t;

endpackage

@@ hdl/condition_filter_segment_finder.sv @@
// Top level of the condition filter and segment finder.
// Depends on cfsf_pkg, cfsf_cfg_regs, cfsf_cond_eval and cfsf_seg_tracker.
//
//   Channel   Direction  Moves                      Handshake
//   s_axis    in         one table row per item     s_axis_tvalid / s_axis_tready
//   m_axis    out        one segment per item       m_axis_tvalid / m_axis_tready
//   cfg       in         one register write         cfg_valid / cfg_ready
//
// One row per cycle while the output is not stalled: a row is held in the input
// register, where both conditions and the run update are evaluated, then any
// segment sits in the output register, from which it is offered once the row
// that closes it moves on.
// Reset clears the configuration, the run flag and the row count.
// A stalled output only holds up the row in the input register when a result
// is still waiting in the output register.
`timescale 1ns / 1ps

module condition_filter_segment_finder
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Row stream.
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // time_stamp [63:0], value_a [127:64], value_b [191:128]
    input  logic [cfsf_pkg::IN_DATA_WIDTH-1:0]       s_axis_tdata,
    // value_a_nan [0], value_b_nan [1]
    input  logic [1:0]                               s_axis_tuser,
    input  logic                                     s_axis_tlast,
    // Segment stream.
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // seg_start_time [63:0], seg_end_time [127:64],
    // seg_start_index [167:128], seg_end_index [207:168]
    output logic [cfsf_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata,
    // Configuration writes.
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [cfsf_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
    input  logic [cfsf_pkg::VALUE_WIDTH-1:0]         cfg_data
);

    cfsf_pkg::cfsf_cfg_t   cfg;
    cfsf_pkg::row_t        row_reg;
    logic                  row_valid_reg;
    logic                  row_take;
    logic                  pass_a;
    logic                  pass_b;
    logic                  row_pass;
    logic                  use_b;
    cfsf_pkg::segment_t    seg;

    cfsf_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: refilled when empty or whenever the held row moves on.
    assign s_axis_tready = !row_valid_reg || row_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            row_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            row_reg.time_stamp  <= $signed(s_axis_tdata[63:0]);
            row_reg.value_a     <= $signed(s_axis_tdata[127:64]);
            row_reg.value_b     <= $signed(s_axis_tdata[191:128]);
            row_reg.value_a_nan <= s_axis_tuser[0];
            row_reg.value_b_nan <= s_axis_tuser[1];
            row_reg.last_row    <= s_axis_tlast;
        end
    end

    // Condition tests.
    cfsf_cond_eval u_cond_a
    (
        .value     (row_reg.value_a),
        .value_nan (row_reg.value_a_nan),
        .cond      (cfg.cond_a),
        .pass      (pass_a)
    );

    cfsf_cond_eval u_cond_b
    (
        .value     (row_reg.value_b),
        .value_nan (row_reg.value_b_nan),
        .cond      (cfg.cond_b),
        .pass      (pass_b)
    );

    // First condition seeds the pass bit, the second combines by AND or OR.
    assign use_b = (cfsf_pkg::NUM_CONDITIONS >= 2) && (cfg.cond_count >= 2'd2);

    always_comb
    begin
        if (cfg.cond_count == '0)
        begin
            row_pass = 1'b1;
        end
        else if (use_b)
        begin
            row_pass = cfg.cond_b.mode[cfsf_pkg::MODE_OR_BIT] ? (pass_a || pass_b)
                                                              : (pass_a && pass_b);
        end
        else
        begin
            row_pass = pass_a;
        end
    end

    cfsf_seg_tracker u_seg_tracker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .row_valid       (row_valid_reg),
        .row             (row_reg),
        .row_pass        (row_pass),
        .first_row_index (cfg.first_row_index),
        .row_take        (row_take),
        .seg_valid       (m_axis_tvalid),
        .seg_ready       (m_axis_tready),
        .seg             (seg)
    );

    // Output packing, first field lowest.
    assign m_axis_tdata = {seg.seg_end_index, seg.seg_start_index,
                           seg.seg_end_time, seg.seg_start_time};

endmodule

@@ hdl/cfsf_cfg_regs.sv @@
// Configuration register file for the condition filter and segment finder.
// Depends on cfsf_pkg.
`timescale 1ns / 1ps

module cfsf_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cfsf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [cfsf_pkg::VALUE_WIDTH-1:0]     cfg_data,
    output cfsf_pkg::cfsf_cfg_t                  cfg
);

    cfsf_pkg::cfsf_cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cfsf_pkg::REG_COND_COUNT:
                    cfg_reg.cond_count <= cfg_data[cfsf_pkg::COUNT_WIDTH-1:0];
                cfsf_pkg::REG_COND_A_MODE:
                    cfg_reg.cond_a.mode <= cfg_data[cfsf_pkg::MODE_WIDTH-1:0];
                cfsf_pkg::REG_COND_A_LOW:
                    cfg_reg.cond_a.low <= $signed(cfg_data);
                cfsf_pkg::REG_COND_A_HIGH:
                    cfg_reg.cond_a.high <= $signed(cfg_data);
                cfsf_pkg::REG_COND_B_MODE:
                    cfg_reg.cond_b.mode <= cfg_data[cfsf_pkg::MODE_WIDTH-1:0];
                cfsf_pkg::REG_COND_B_LOW:
                    cfg_reg.cond_b.low <= $signed(cfg_data);
                cfsf_pkg::REG_COND_B_HIGH:
                    cfg_reg.cond_b.high <= $signed(cfg_data);
                cfsf_pkg::REG_FIRST_ROW_INDEX:
                    cfg_reg.first_row_index <= cfg_data[cfsf_pkg::INDEX_WIDTH-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

@@ hdl/cfsf_cond_eval.sv @@
// Evaluates one condition against one Q32.32 value.
// Depends on cfsf_pkg.
`timescale 1ns / 1ps

module cfsf_cond_eval
(
    input  logic signed [cfsf_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                    value_nan,
    input  cfsf_pkg::cond_cfg_t                     cond,
    output logic                                    pass
);

    cfsf_pkg::cond_type_t cond_type;

    assign cond_type = cfsf_pkg::cond_type_t'(cond.mode[2:0]);

    // Signed compares; a flagged value and unknown types fail.
    always_comb
    begin
        pass = 1'b0;
        if (!value_nan)
        begin
            unique case (cond_type)
                cfsf_pkg::COND_RANGE:     pass = (value >= cond.low) && (value <= cond.high);
                cfsf_pkg::COND_GREATER:   pass = value > cond.low;
                cfsf_pkg::COND_LESS:      pass = value < cond.low;
                cfsf_pkg::COND_EQUAL:     pass = value == cond.low;
                cfsf_pkg::COND_NOT_EQUAL: pass = value != cond.low;
                default:                  pass = 1'b0;
            endcase
        end
    end

endmodule

@@ hdl/cfsf_seg_tracker.sv @@
// Run tracking, row indexing and the segment output register.
// Depends on cfsf_pkg.
`timescale 1ns / 1ps

module cfsf_seg_tracker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                row_valid,
    input  cfsf_pkg::row_t                      row,
    input  logic                                row_pass,
    input  logic [cfsf_pkg::INDEX_WIDTH-1:0]    first_row_index,
    output logic                                row_take,
    output logic                                seg_valid,
    input  logic                                seg_ready,
    output cfsf_pkg::segment_t                  seg
);

    logic                                 in_run_reg;
    logic                                 in_run_next;
    logic signed [cfsf_pkg::VALUE_WIDTH-1:0] run_start_time_reg;
    logic signed [cfsf_pkg::VALUE_WIDTH-1:0] run_start_time_next;
    logic [cfsf_pkg::INDEX_WIDTH-1:0]     run_start_index_reg;
    logic [cfsf_pkg::INDEX_WIDTH-1:0]     run_start_index_next;
    logic signed [cfsf_pkg::VALUE_WIDTH-1:0] previous_time_reg;
    logic [cfsf_pkg::INDEX_WIDTH-1:0]     row_offset_reg;
    logic [cfsf_pkg::INDEX_WIDTH-1:0]     row_offset_next;
    logic [cfsf_pkg::INDEX_WIDTH-1:0]     row_index;
    logic                                 seg_valid_reg;
    cfsf_pkg::segment_t                   seg_reg;
    cfsf_pkg::segment_t                   seg_next;
    logic                                 emit;

    // The row moves on whenever the output register can take a result.
    assign row_take  = row_valid && (!seg_valid_reg || seg_ready);
    assign row_index = first_row_index + row_offset_reg;
    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    // Run update for the row at hand.
    always_comb
    begin
        in_run_next          = in_run_reg;
        run_start_time_next  = run_start_time_reg;
        run_start_index_next = run_start_index_reg;
        emit                 = 1'b0;
        seg_next             = seg_reg;
        row_offset_next      = row_offset_reg + 1'b1;

        if (row_pass && !in_run_reg)
        begin
            in_run_next          = 1'b1;
            run_start_time_next  = row.time_stamp;
            run_start_index_next = row_index;
        end
        else if (!row_pass && in_run_reg)
        begin
            // A failing row closes the run at the previous row.
            in_run_next              = 1'b0;
            emit                     = 1'b1;
            seg_next.seg_start_time  = run_start_time_reg;
            seg_next.seg_end_time    = previous_time_reg;
            seg_next.seg_start_index = run_start_index_reg;
            seg_next.seg_end_index   = (row_index == '0) ? '0 : row_index - 1'b1;
        end

        if (row.last_row)
        begin
            if (in_run_next)
            begin
                emit                     = 1'b1;
                seg_next.seg_start_time  = run_start_time_next;
                seg_next.seg_end_time    = row.time_stamp;
                seg_next.seg_start_index = run_start_index_next;
                seg_next.seg_end_index   = row_index;
            end
            in_run_next     = 1'b0;
            row_offset_next = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg     <= 1'b0;
            row_offset_reg <= '0;
            seg_valid_reg  <= 1'b0;
        end
        else
        begin
            if (row_take)
            begin
                in_run_reg     <= in_run_next;
                row_offset_reg <= row_offset_next;
            end
            if (row_take && emit)
            begin
                seg_valid_reg <= 1'b1;
            end
            else if (seg_ready)
            begin
                seg_valid_reg <= 1'b0;
            end
        end
    end

    // Run payload and the result register.
    always_ff @(posedge clk)
    begin
        if (row_take)
        begin
            run_start_time_reg  <= run_start_time_next;
            run_start_index_reg <= run_start_index_next;
            previous_time_reg   <= row.time_stamp;
            if (emit)
            begin
                seg_reg <= seg_next;
            end
        end
    end

    // The last row always leaves the block with no open run and a fresh count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_take && row.last_row) |=> (!in_run_reg && row_offset_reg == '0))
        else $error("run state not cleared after last row");

    // A new result only appears when a row was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seg_valid_reg) |-> $past(row_take))
        else $error("segment produced without a row");

    // Opening a run captures the time of the row that opened it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_run_reg) |-> (run_start_time_reg == $past(row.time_stamp)))
        else $error("run start time not captured");

    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid_reg && !seg_ready) |=> (seg_valid_reg && $stable(seg_reg)))
        else $error("pending segment lost");

endmodule

@@ test/segment_checker.sv @@
`timescale 1ns / 1ps
// Checker for condition_filter_segment_finder: watches the row, segment and
// configuration channels, predicts every segment and compares it field by field.
// Depends on cfsf_pkg.

module segment_checker
    import cfsf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // time_stamp [63:0], value_a [127:64], value_b [191:128]
    input  logic [IN_DATA_WIDTH-1:0]    s_axis_tdata,
    // value_a_nan [0], value_b_nan [1]
    input  logic [1:0]                  s_axis_tuser,
    input  logic                        s_axis_tlast,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // seg_start_time [63:0], seg_end_time [127:64],
    // seg_start_index [167:128], seg_end_index [207:168]
    input  logic [OUT_DATA_WIDTH-1:0]   m_axis_tdata,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [VALUE_WIDTH-1:0]      cfg_data,
    output int                          fail_count,
    output int                          segments_pending
);

    // Shadow copy of the configuration registers.
    logic [COUNT_WIDTH-1:0]        active_conditions;
    cond_cfg_t                     cond_a_cfg;
    cond_cfg_t                     cond_b_cfg;
    logic [INDEX_WIDTH-1:0]        base_index;

    // Shadow copy of the run tracker.
    logic                          in_run;
    logic signed [VALUE_WIDTH-1:0] run_start_time;
    logic [INDEX_WIDTH-1:0]        run_start_index;
    logic signed [VALUE_WIDTH-1:0] previous_time;
    logic [INDEX_WIDTH-1:0]        row_offset;

    // Segments predicted but not yet seen on the output.
    segment_t expected_segments[$];

    initial fail_count = 0;

    // One condition on one value. A flagged value and an unknown type fail.
    function automatic logic cond_holds(input logic [VALUE_WIDTH-1:0] value,
                                        input logic nan, input cond_cfg_t c);
        logic signed [VALUE_WIDTH-1:0] v;
        logic signed [VALUE_WIDTH-1:0] lo;
        logic signed [VALUE_WIDTH-1:0] hi;
        v  = $signed(value);
        lo = $signed(c.low);
        hi = $signed(c.high);
        if (nan)
            return 1'b0;
        case (c.mode[2:0])
            COND_RANGE:     return (v >= lo) && (v <= hi);
            COND_GREATER:   return v > lo;
            COND_LESS:      return v < lo;
            COND_EQUAL:     return v == lo;
            COND_NOT_EQUAL: return v != lo;
            default:        return 1'b0;
        endcase
    endfunction

    // Mirror one register write; unknown indexes are dropped.
    task automatic apply_config(input logic [CFG_IDX_WIDTH-1:0] idx,
                                input logic [VALUE_WIDTH-1:0] data);
        case (idx)
            REG_COND_COUNT:      active_conditions = data[COUNT_WIDTH-1:0];
            REG_COND_A_MODE:     cond_a_cfg.mode = data[MODE_WIDTH-1:0];
            REG_COND_A_LOW:      cond_a_cfg.low = data;
            REG_COND_A_HIGH:     cond_a_cfg.high = data;
            REG_COND_B_MODE:     cond_b_cfg.mode = data[MODE_WIDTH-1:0];
            REG_COND_B_LOW:      cond_b_cfg.low = data;
            REG_COND_B_HIGH:     cond_b_cfg.high = data;
            REG_FIRST_ROW_INDEX: base_index = data[INDEX_WIDTH-1:0];
            default:             ;
        endcase
    endtask

    // Evaluate one accepted row and queue the segment it closes, if any.
    task automatic predict_row(input logic [IN_DATA_WIDTH-1:0] data,
                               input logic [1:0] user, input logic last_row);
        logic [VALUE_WIDTH-1:0] stamp;
        logic [INDEX_WIDTH-1:0] idx;
        logic                   pass;
        logic                   pass_b;
        int                     used;
        segment_t               seg;
        stamp = data[0 +: VALUE_WIDTH];
        idx   = base_index + row_offset;
        used  = (active_conditions > NUM_CONDITIONS) ? NUM_CONDITIONS : active_conditions;

        // The first condition seeds the pass bit; the second joins by AND or OR.
        pass = 1'b1;
        if (used >= 1)
            pass = cond_holds(data[VALUE_WIDTH +: VALUE_WIDTH], user[0], cond_a_cfg);
        if (used >= 2)
        begin
            pass_b = cond_holds(data[2*VALUE_WIDTH +: VALUE_WIDTH], user[1], cond_b_cfg);
            pass = cond_b_cfg.mode[MODE_OR_BIT] ? (pass || pass_b) : (pass && pass_b);
        end

        // Open a run, or close it at the previous row.
        if (pass && !in_run)
        begin
            in_run          = 1'b1;
            run_start_time  = stamp;
            run_start_index = idx;
        end
        else if (!pass && in_run)
        begin
            seg.seg_start_time  = run_start_time;
            seg.seg_end_time    = previous_time;
            seg.seg_start_index = run_start_index;
            seg.seg_end_index   = (idx == '0) ? '0 : idx - 1'b1;
            expected_segments.push_back(seg);
            in_run = 1'b0;
        end
        previous_time = stamp;

        // The last row flushes any open run through itself and restarts the count.
        if (last_row)
        begin
            if (in_run)
            begin
                seg.seg_start_time  = run_start_time;
                seg.seg_end_time    = stamp;
                seg.seg_start_index = run_start_index;
                seg.seg_end_index   = idx;
                expected_segments.push_back(seg);
            end
            in_run     = 1'b0;
            row_offset = '0;
        end
        else
        begin
            row_offset = row_offset + 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [VALUE_WIDTH-1:0] want,
                                 input logic [VALUE_WIDTH-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Match one output segment against the oldest prediction.
    task automatic check_segment(input logic [OUT_DATA_WIDTH-1:0] data);
        segment_t want;
        if (expected_segments.size() == 0)
        begin
            $error("segment item with no segment expected: start_index %h",
                   data[2*VALUE_WIDTH +: INDEX_WIDTH]);
            fail_count++;
        end
        else
        begin
            want = expected_segments.pop_front();
            compare_field("seg_start_time", want.seg_start_time, data[0 +: VALUE_WIDTH]);
            compare_field("seg_end_time", want.seg_end_time,
                          data[VALUE_WIDTH +: VALUE_WIDTH]);
            compare_field("seg_start_index", VALUE_WIDTH'(want.seg_start_index),
                          VALUE_WIDTH'(data[2*VALUE_WIDTH +: INDEX_WIDTH]));
            compare_field("seg_end_index", VALUE_WIDTH'(want.seg_end_index),
                          VALUE_WIDTH'(data[2*VALUE_WIDTH+INDEX_WIDTH +: INDEX_WIDTH]));
        end
    endtask

    // Sample all three channels at each edge; outputs first, then new rows.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_conditions = '0;
            cond_a_cfg        = '0;
            cond_b_cfg        = '0;
            base_index        = '0;
            in_run            = 1'b0;
            run_start_time    = '0;
            run_start_index   = '0;
            previous_time     = '0;
            row_offset        = '0;
            expected_segments.delete();
            segments_pending  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_segment(m_axis_tdata);
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_row(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            segments_pending = expected_segments.size();
        end
    end

endmodule

@@ test/tb_condition_filter_segment_finder.sv @@
`timescale 1ns / 1ps
// Testbench top for condition_filter_segment_finder: drives directed and random
// rows and register writes under random idling; segment_checker does the checking.
// Depends on cfsf_pkg, segment_checker and the block itself.

module tb_condition_filter_segment_finder;
    import cfsf_pkg::*;

    localparam int                       ROW_TARGET    = 530;
    localparam int                       SETTLE_CYCLES = 8;
    localparam int                       WATCHDOG_NS   = 2000000;
    localparam logic [VALUE_WIDTH-1:0]   Q_MIN         = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_WIDTH-1:0]   Q_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [INDEX_WIDTH-1:0]   INDEX_MAX     = '1;
    localparam logic [2:0]               COND_UNKNOWN  = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED    = 4'd9;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]   s_axis_tdata;
    logic [1:0]                 s_axis_tuser;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index;
    logic [VALUE_WIDTH-1:0]     cfg_data;

    int fail_count;
    int segments_pending;
    int rows_sent      = 0;
    int send_idle_pct  = 13;
    int recv_stall_pct = 87;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    condition_filter_segment_finder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    segment_checker u_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .segments_pending (segments_pending)
    );

    // Segment receiver stalls at random.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [VALUE_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write every register, then release the channel.
    task automatic load_config(input cfsf_cfg_t c);
        write_reg(REG_COND_COUNT, VALUE_WIDTH'(c.cond_count));
        write_reg(REG_COND_A_MODE, VALUE_WIDTH'(c.cond_a.mode));
        write_reg(REG_COND_A_LOW, c.cond_a.low);
        write_reg(REG_COND_A_HIGH, c.cond_a.high);
        write_reg(REG_COND_B_MODE, VALUE_WIDTH'(c.cond_b.mode));
        write_reg(REG_COND_B_LOW, c.cond_b.low);
        write_reg(REG_COND_B_HIGH, c.cond_b.high);
        write_reg(REG_FIRST_ROW_INDEX, VALUE_WIDTH'(c.first_row_index));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let every segment come out, then let the bench settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (segments_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one row after a random gap and hold it until accepted.
    task automatic send_row(input row_t r);
        if (rows_sent < ROW_TARGET / 3)
        begin
            send_idle_pct  = 13;
            recv_stall_pct = 87;
        end
        else if (rows_sent < 2 * ROW_TARGET / 3)
        begin
            send_idle_pct  = 87;
            recv_stall_pct = 13;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.value_b, r.value_a, r.time_stamp};
        s_axis_tuser  <= {r.value_b_nan, r.value_a_nan};
        s_axis_tlast  <= r.last_row;
        do @(posedge clk); while (!s_axis_tready);
        rows_sent++;
    endtask

    function automatic row_t make_row(input logic [VALUE_WIDTH-1:0] stamp,
                                      input logic [VALUE_WIDTH-1:0] va,
                                      input logic [VALUE_WIDTH-1:0] vb,
                                      input logic na, input logic nb, input logic last_row);
        row_t r;
        r.time_stamp  = stamp;
        r.value_a     = va;
        r.value_b     = vb;
        r.value_a_nan = na;
        r.value_b_nan = nb;
        r.last_row    = last_row;
        return r;
    endfunction

    // Thresholds: extremes, zero, full random, small raw and whole Q32.32 values.
    function automatic logic [VALUE_WIDTH-1:0] pick_bound();
        logic signed [VALUE_WIDTH-1:0] v;
        case ($urandom_range(6))
            0: v = Q_MIN;
            1: v = Q_MAX;
            2: v = '0;
            3: v = {$urandom, $urandom};
            4:
            begin
                v = VALUE_WIDTH'($urandom_range(200));
                v = v - VALUE_WIDTH'(100);
            end
            default: v = {32'($urandom_range(40)) - 32'd20, 32'd0};
        endcase
        return v;
    endfunction

    // Values cluster on the edges of a condition so that runs open and close.
    function automatic logic [VALUE_WIDTH-1:0] near_bound(input cond_cfg_t k);
        case ($urandom_range(7))
            0: return k.low;
            1: return k.low + 1'b1;
            2: return k.low - 1'b1;
            3: return k.high;
            4: return k.high + 1'b1;
            5: return k.low + VALUE_WIDTH'($urandom_range(1000));
            6: return pick_bound();
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic cond_cfg_t random_cond();
        cond_cfg_t k;
        logic [2:0] kind;
        kind   = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        k.mode = {1'($urandom_range(1)), kind};
        k.low  = pick_bound();
        if ($urandom_range(4) == 0)
            k.high = pick_bound();
        else
            k.high = k.low + VALUE_WIDTH'($urandom_range(1000));
        return k;
    endfunction

    function automatic cfsf_cfg_t random_config();
        cfsf_cfg_t c;
        c.cond_count = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd2;
        c.cond_a     = random_cond();
        c.cond_b     = random_cond();
        case ($urandom_range(3))
            0:       c.first_row_index = '0;
            1:       c.first_row_index = INDEX_MAX - INDEX_WIDTH'($urandom_range(20));
            default: c.first_row_index = INDEX_WIDTH'({$urandom, $urandom});
        endcase
        return c;
    endfunction

    function automatic row_t random_row(input cfsf_cfg_t c);
        return make_row({$urandom, $urandom}, near_bound(c.cond_a), near_bound(c.cond_b),
                        $urandom_range(9) == 0, $urandom_range(9) == 0,
                        $urandom_range(15) == 0);
    endfunction

    // Stimulus and verdict.
    initial
    begin
        cfsf_cfg_t c;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no conditions, so every row passes; extreme timestamps.
        send_row(make_row(Q_MIN, Q_MAX, Q_MIN, 1'b1, 1'b1, 1'b0));
        send_row(make_row(Q_MAX, '0, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row('0, Q_MIN, Q_MAX, 1'b0, 1'b0, 1'b1));
        drain();

        // Full-scale range on the first value only; OR bit ignored there; flagged value.
        c = '{cond_count: 2'd1, cond_a: '{{1'b1, COND_RANGE}, Q_MIN, Q_MAX},
              cond_b: '0, first_row_index: 40'd5};
        load_config(c);
        send_row(make_row(64'd1, Q_MIN, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd2, Q_MAX, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd3, '0, '0, 1'b1, 1'b0, 1'b0));
        send_row(make_row(64'd4, '0, '0, 1'b0, 1'b0, 1'b1));
        drain();

        // Greater OR less, with the boundary and a flagged second value.
        c = '{cond_count: 2'd2, cond_a: '{{1'b0, COND_GREATER}, '0, '0},
              cond_b: '{{1'b1, COND_LESS}, '0, '0}, first_row_index: '0};
        load_config(c);
        send_row(make_row(64'd10, 64'd1, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd11, '0, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd12, '0, '1, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd13, '0, '1, 1'b0, 1'b1, 1'b0));
        send_row(make_row(64'd14, 64'd1, '0, 1'b0, 1'b0, 1'b1));
        drain();

        // Count above the limit; equal AND not-equal; index wraps to zero on the closing row.
        c = '{cond_count: 2'd3, cond_a: '{{1'b0, COND_EQUAL}, Q_MAX, '0},
              cond_b: '{{1'b0, COND_NOT_EQUAL}, '0, '0},
              first_row_index: INDEX_MAX - 1'b1};
        load_config(c);
        send_row(make_row(64'd20, Q_MAX, 64'd1, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd21, Q_MAX, Q_MIN, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd22, Q_MAX, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd23, '0, 64'd1, 1'b0, 1'b0, 1'b1));
        drain();

        // Unknown type OR an inverted range: nothing passes; a write to no register.
        c = '{cond_count: 2'd2, cond_a: '{{1'b0, COND_UNKNOWN}, '0, Q_MAX},
              cond_b: '{{1'b1, COND_RANGE}, 64'd10, -64'sd10}, first_row_index: '0};
        load_config(c);
        write_reg(REG_UNUSED, 64'd1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_row(make_row(64'd30, 64'd10, '0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(64'd31, '0, '0, 1'b0, 1'b0, 1'b1));
        drain();

        // Random phases, each under a fresh configuration.
        while (rows_sent < ROW_TARGET)
        begin
            c = random_config();
            load_config(c);
            repeat ($urandom_range(60, 15)) send_row(random_row(c));
            drain();
        end

        if (fail_count == 0 && segments_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #WATCHDOG_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
